/* rtl/vssc_pkg.sv */
`timescale 1ns / 1ps

package vssc_pkg;

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // field widths
    localparam int HR_W    = 12;
    localparam int TEMP_W  = 13;
    localparam int GSR_W   = 12;
    localparam int LEVEL_W = 3;

    // score in Q1.16, 1.0 = 65536
    localparam int SCORE_W = 17;
    // weighted sum, 1.0 = 6553600
    localparam int SUM_W   = 23;

    // heart rate breakpoints, tenths of bpm
    localparam logic [HR_W-1:0] HR_T0 = 12'd700;
    localparam logic [HR_W-1:0] HR_T1 = 12'd1000;
    localparam logic [HR_W-1:0] HR_T2 = 12'd1300;
    localparam logic [HR_W-1:0] HR_T3 = 12'd1600;

    // temperature breakpoints, hundredths of a degree
    localparam logic [TEMP_W-1:0] TEMP_T0    = 13'd3650;
    localparam logic [TEMP_W-1:0] TEMP_T1    = 13'd3750;
    localparam logic [TEMP_W-1:0] TEMP_T2    = 13'd3800;
    localparam logic [TEMP_W-1:0] TEMP_EMERG = 13'd3900;

    // skin conductance breakpoints, raw counts
    localparam logic [GSR_W-1:0] GSR_T0 = 12'd300;
    localparam logic [GSR_W-1:0] GSR_T1 = 12'd600;
    localparam logic [GSR_W-1:0] GSR_T2 = 12'd900;
    localparam logic [GSR_W-1:0] GSR_T3 = 12'd1200;

    // reciprocals for exact floor division by 375 and by 25
    localparam int RECIP375_W     = 26;
    localparam logic [RECIP375_W-1:0] RECIP375 = 26'd45812985;
    localparam int RECIP375_SHIFT = 21;
    localparam int RECIP25_W      = 22;
    localparam logic [RECIP25_W-1:0] RECIP25 = 22'd2684355;
    localparam int RECIP25_SHIFT  = 13;

    localparam logic [SUM_W-1:0] SUM_ONE = 23'd6553600;

    localparam logic [SUM_W-1:0] LEVEL_BOUNDS [7] = '{
        23'd327680, 23'd983040, 23'd1966080, 23'd2949120,
        23'd3932160, 23'd4915200, 23'd5898240
    };

    localparam logic [LEVEL_W-1:0] LEVEL_HR_FLOOR = 3'd6;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 3'd7;

    typedef struct packed {
        logic [SCORE_W-1:0] hr;
        logic [SCORE_W-1:0] gsr;
        logic [SCORE_W-1:0] temp;
        logic               hr_high;
        logic               emergency;
    } score_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] stress_level;
        logic               emergency;
    } result_t;

endpackage

/* rtl/vssc_score.sv */
`timescale 1ns / 1ps

module vssc_score
    import vssc_pkg::*;
(
    input  logic [HR_W-1:0]   heart_rate,
    input  logic [TEMP_W-1:0] body_temp,
    input  logic [GSR_W-1:0]  skin_conductance,
    output score_t            score
);

    // numerator in units of 1/3000 of full scale for the three-segment curve
    function automatic logic [11:0] three_seg_num(
        input logic [11:0] x,
        input logic [11:0] a,
        input logic [11:0] b,
        input logic [11:0] c,
        input logic [11:0] d
    );
        logic [11:0] num;
        if (x <= a)
            num = 12'd0;
        else if (x <= b)
            num = 12'((x - a) << 2);
        else if (x <= c)
            num = 12'd1200 + 12'((x - b) << 2);
        else if (x <= d)
            num = 12'd2400 + 12'((x - c) << 1);
        else
            num = 12'd3000;
        return num;
    endfunction

    logic [11:0] hr_num;
    logic [11:0] gsr_num;
    logic [7:0]  temp_num;
    logic [RECIP375_W+11:0] hr_prod;
    logic [RECIP375_W+11:0] gsr_prod;
    logic [RECIP25_W+7:0]   temp_prod;

    assign hr_num  = three_seg_num(heart_rate, HR_T0, HR_T1, HR_T2, HR_T3);
    assign gsr_num = three_seg_num(skin_conductance, GSR_T0, GSR_T1, GSR_T2, GSR_T3);

    // temperature numerator in units of 1/200 of full scale
    always_comb
    begin
        if (body_temp <= TEMP_T0)
            temp_num = 8'd0;
        else if (body_temp <= TEMP_T1)
            temp_num = 8'(body_temp - TEMP_T0);
        else if (body_temp <= TEMP_T2)
            temp_num = 8'd100 + 8'((body_temp - TEMP_T1) << 1);
        else
            temp_num = 8'd200;
    end

    // floor(8192*num/375) and floor(8192*num/25)
    assign hr_prod   = hr_num * RECIP375;
    assign gsr_prod  = gsr_num * RECIP375;
    assign temp_prod = temp_num * RECIP25;

    assign score.hr        = hr_prod[RECIP375_SHIFT +: SCORE_W];
    assign score.gsr       = gsr_prod[RECIP375_SHIFT +: SCORE_W];
    assign score.temp      = temp_prod[RECIP25_SHIFT +: SCORE_W];
    assign score.hr_high   = (heart_rate > HR_T2);
    assign score.emergency = (heart_rate > HR_T3) || (body_temp > TEMP_EMERG);

endmodule

/* rtl/vssc_level.sv */
`timescale 1ns / 1ps

module vssc_level
    import vssc_pkg::*;
(
    input  score_t  score,
    output result_t result
);

    logic [SUM_W-1:0]   sum_raw;
    logic [SUM_W-1:0]   sum_sat;
    logic [LEVEL_W-1:0] level_base;

    // 50/35/15 weighting, scale 1.0 = 6553600
    assign sum_raw = SUM_W'(score.hr) * 23'd50 + SUM_W'(score.gsr) * 23'd35
                   + SUM_W'(score.temp) * 23'd15;
    assign sum_sat = (sum_raw > SUM_ONE) ? SUM_ONE : sum_raw;

    always_comb
    begin
        level_base = LEVEL_MAX;
        for (int i = 6; i >= 0; i--)
        begin
            if (sum_sat <= LEVEL_BOUNDS[i])
                level_base = LEVEL_W'(i);
        end
    end

    always_comb
    begin
        result.emergency = score.emergency;
        priority if (score.emergency)
            result.stress_level = LEVEL_MAX;
        else if (score.hr_high && (level_base < LEVEL_HR_FLOOR))
            result.stress_level = LEVEL_HR_FLOOR;
        else
            result.stress_level = level_base;
    end

endmodule

/* rtl/vital_sign_stress_classifier.sv */
`timescale 1ns / 1ps
// path: an accepted sample goes through the score register and the result register to m_tvalid
// throughput: one sample per cycle while m_tready is high; three-stage pipeline, no loops
// stages: input register, score register after the reciprocal multipliers, result register
// a full pipeline keeps taking samples while m_tready is low only until all three stages hold
// reset: rst_n low clears every stage valid flag at once, so no stale result is shown
module vital_sign_stress_classifier
    import vssc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // sample stream in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [11:0] heart_rate, [24:12] body_temp, [36:25] skin_conductance, [39:37] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // classification stream out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] stress_level, [3] emergency, [7:4] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    // stage valid flags
    logic in_valid_reg,    in_valid_next;
    logic score_valid_reg, score_valid_next;
    logic res_valid_reg,   res_valid_next;

    // stage payloads
    logic [HR_W-1:0]   hr_reg;
    logic [TEMP_W-1:0] temp_reg;
    logic [GSR_W-1:0]  gsr_reg;
    score_t            score_reg;
    result_t           res_reg;

    score_t  score_comb;
    result_t res_comb;

    // each stage can load when empty or when it hands its item on in this cycle
    logic res_ready;
    logic score_ready;
    logic in_ready;
    logic in_take;

    assign res_ready   = !res_valid_reg || m_tready;
    assign score_ready = !score_valid_reg || res_ready;
    assign in_ready    = !in_valid_reg || score_ready;
    assign s_tready    = in_ready;
    assign in_take     = s_tvalid && in_ready;

    assign in_valid_next    = in_ready ? s_tvalid : in_valid_reg;
    assign score_valid_next = score_ready ? in_valid_reg : score_valid_reg;
    assign res_valid_next   = res_ready ? score_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            score_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            score_valid_reg <= score_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hr_reg   <= s_tdata[11:0];
            temp_reg <= s_tdata[24:12];
            gsr_reg  <= s_tdata[36:25];
        end
    end

    // piecewise-linear scores plus override flags
    vssc_score u_score (
        .heart_rate       (hr_reg),
        .body_temp        (temp_reg),
        .skin_conductance (gsr_reg),
        .score            (score_comb)
    );

    always_ff @(posedge clk)
    begin
        if (score_ready && in_valid_reg)
            score_reg <= score_comb;
    end

    // weighting, level breakpoints and overrides
    vssc_level u_level (
        .score  (score_reg),
        .result (res_comb)
    );

    always_ff @(posedge clk)
    begin
        if (res_ready && score_valid_reg)
            res_reg <= res_comb;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {4'b0000, res_reg.emergency, res_reg.stress_level};

    // an emergency always comes with the top level
    a_emerg_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == LEVEL_MAX)
        else $error("emergency without top stress level");

    // a fast heart rate never leaves the level below the floor
    a_hr_floor: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid_reg && res_ready && score_reg.hr_high
        |=> res_reg.stress_level >= LEVEL_HR_FLOOR)
        else $error("heart rate override missed");

    // an accepted sample always lands in the input stage
    a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted sample lost at input stage");

    // after a hand-off with nothing in the score stage, the result stage empties
    a_res_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !score_valid_reg |=> !m_tvalid)
        else $error("result repeated after hand-off");

endmodule
